>>> rtl/amd_pkg.sv
// Shared types and constants for the accelerometer motion detector.
// No dependencies; every other rtl file imports this package.
package amd_pkg;

  localparam int AXIS_W        = 16;
  localparam int SQUARE_W      = 31;
  localparam int SUMSQ_W       = 32;
  localparam int MAG_W         = 16;
  localparam int PCT_W         = 7;
  localparam int RUN_W         = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 3;

  localparam int LEARN_SAMPLES = 25;
  localparam int LEARN_CNT_W   = 8;
  localparam int LEARN_SUM_W   = 24;

  localparam int ROOT_STEPS    = SUMSQ_W / 2;
  localparam int ROOT_CNT_W    = $clog2(ROOT_STEPS);
  localparam int ROOT_REM_W    = MAG_W + 1;

  // Constant division by reciprocal multiply plus one correction step.
  localparam int PCT_SCALE     = 100;
  localparam int DIVISOR_W     = 8;
  localparam int DIV_NUM_W     = 24;
  localparam int RECIP_SHIFT   = 30;
  localparam int RECIP_W       = 31;
  localparam int DIV_PROD_W    = DIV_NUM_W + RECIP_W;
  localparam int THRESH_W      = 17;
  localparam logic [RECIP_W-1:0] RECIP_LEARN =
    RECIP_W'((64'd1 << RECIP_SHIFT) / LEARN_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP_PCT =
    RECIP_W'((64'd1 << RECIP_SHIFT) / PCT_SCALE);

  localparam int TRACK_SHIFT   = 8;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ON_PERCENT     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_PERCENT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ON_RUN_LENGTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_RUN_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REST_MINIMUM   = 3'd4;

  localparam logic [PCT_W-1:0] ON_PCT_RESET  = 7'd25;
  localparam logic [PCT_W-1:0] OFF_PCT_RESET = 7'd12;
  localparam logic [RUN_W-1:0] ON_RUN_RESET  = 8'd3;
  localparam logic [RUN_W-1:0] OFF_RUN_RESET = 8'd15;
  localparam logic [MAG_W-1:0] REST_MIN_RESET = 16'd100;

  typedef struct packed {
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
  } amd_in_t;

  typedef struct packed {
    logic             motion;
    logic             motion_changed;
    logic [MAG_W-1:0] magnitude;
    logic [MAG_W-1:0] deviation;
    logic [MAG_W-1:0] rest_level;
    logic             learned;
  } amd_out_t;

  typedef struct packed {
    logic [PCT_W-1:0] on_percent;
    logic [PCT_W-1:0] off_percent;
    logic [RUN_W-1:0] on_run_length;
    logic [RUN_W-1:0] off_run_length;
    logic [MAG_W-1:0] rest_minimum;
  } amd_cfg_t;

endpackage

>>> rtl/amd_front.sv
// Front end: accepts samples, squares the three axes and sums them.
// Depends on amd_pkg.
module amd_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  amd_pkg::amd_in_t        in_item,
  output logic                    push_valid,
  input  logic                    push_ready,
  output logic [amd_pkg::SUMSQ_W-1:0] push_data
);
  import amd_pkg::*;

  logic                sq_valid;
  logic [SQUARE_W-1:0] sq_x;
  logic [SQUARE_W-1:0] sq_y;
  logic [SQUARE_W-1:0] sq_z;
  logic [AXIS_W-1:0]   abs_x;
  logic [AXIS_W-1:0]   abs_y;
  logic [AXIS_W-1:0]   abs_z;
  logic [SUMSQ_W-1:0]  prod_x;
  logic [SUMSQ_W-1:0]  prod_y;
  logic [SUMSQ_W-1:0]  prod_z;

  // Magnitude of -32768 is 0x8000 read as unsigned, which is exact.
  always_comb begin
    abs_x  = in_item.accel_x[AXIS_W-1] ? AXIS_W'(-in_item.accel_x) : in_item.accel_x;
    abs_y  = in_item.accel_y[AXIS_W-1] ? AXIS_W'(-in_item.accel_y) : in_item.accel_y;
    abs_z  = in_item.accel_z[AXIS_W-1] ? AXIS_W'(-in_item.accel_z) : in_item.accel_z;
    prod_x = SUMSQ_W'(abs_x) * SUMSQ_W'(abs_x);
    prod_y = SUMSQ_W'(abs_y) * SUMSQ_W'(abs_y);
    prod_z = SUMSQ_W'(abs_z) * SUMSQ_W'(abs_z);
  end

  assign in_ready   = !sq_valid || push_ready;
  assign push_valid = sq_valid;
  assign push_data  = SUMSQ_W'(sq_x) + SUMSQ_W'(sq_y) + SUMSQ_W'(sq_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      sq_valid <= 1'b1;
    end else if (push_ready) begin
      sq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sq_x <= prod_x[SQUARE_W-1:0];
      sq_y <= prod_y[SQUARE_W-1:0];
      sq_z <= prod_z[SQUARE_W-1:0];
    end
  end

endmodule

>>> rtl/amd_queue.sv
// Short queue of summed squares between the front end and the back end.
// Depends on amd_pkg.
module amd_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_valid,
  output logic                        push_ready,
  input  logic [amd_pkg::SUMSQ_W-1:0] push_data,
  output logic                        pop_valid,
  input  logic                        pop_ready,
  output logic [amd_pkg::SUMSQ_W-1:0] pop_data
);
  import amd_pkg::*;

  logic [SUMSQ_W-1:0]     entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;
  logic                   pop;

  assign push_ready = count != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> rtl/amd_back.sv
// Back end: bit-serial square root, rest learning, thresholds, run counters.
// Depends on amd_pkg; fed from amd_queue, drives the result register.
module amd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  amd_pkg::amd_cfg_t           cfg,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  logic [amd_pkg::SUMSQ_W-1:0] pop_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output amd_pkg::amd_out_t           out_item
);
  import amd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ROOT   = 8'b0000_0010,
    S_CLASS  = 8'b0000_0100,
    S_DMUL   = 8'b0000_1000,
    S_DFIX   = 8'b0001_0000,
    S_OFFMUL = 8'b0010_0000,
    S_DECIDE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    DEST_REST = 2'd0,
    DEST_ON   = 2'd1,
    DEST_OFF  = 2'd2
  } dest_t;

  state_t                  state;
  dest_t                   dest;
  logic [ROOT_CNT_W-1:0]   root_cnt;
  logic [SUMSQ_W-1:0]      rad;
  logic [ROOT_REM_W-1:0]   rem;
  logic [MAG_W-1:0]        root;
  logic [DIV_NUM_W-1:0]    num;
  logic [DIV_PROD_W-1:0]   div_prod;
  logic [THRESH_W-1:0]     on_th;
  logic [THRESH_W-1:0]     off_th;
  logic [LEARN_CNT_W-1:0]  learn_count;
  logic [LEARN_SUM_W-1:0]  learn_sum;
  logic [MAG_W-1:0]        rest_value;
  logic [RUN_W-1:0]        high_run;
  logic [RUN_W-1:0]        low_run;
  logic                    motion_flag;
  logic                    changed;
  logic [MAG_W-1:0]        last_deviation;

  // root step
  logic [ROOT_REM_W+1:0]   rem_sh;
  logic [ROOT_REM_W+1:0]   trial;
  logic                    take;
  // classification
  logic                    learning;
  logic                    learn_done;
  logic [LEARN_SUM_W-1:0]  sum_next;
  logic [LEARN_CNT_W-1:0]  count_next;
  logic [MAG_W-1:0]        dev;
  // constant divider
  logic [DIVISOR_W-1:0]    divisor;
  logic [RECIP_W-1:0]      recip;
  logic [DIV_NUM_W-1:0]    q_est;
  logic [SUMSQ_W-1:0]      q_back;
  logic [DIV_NUM_W:0]      fix_rem;
  logic [DIV_NUM_W-1:0]    q_fix;
  // decision
  logic                    dev_high;
  logic                    dev_low;
  logic [RUN_W-1:0]        high_inc;
  logic [RUN_W-1:0]        low_inc;
  logic                    motion_next;
  logic                    rest_below;
  logic [MAG_W-1:0]        track_step;
  logic [MAG_W-1:0]        rest_next;
  logic                    load_out;

  always_comb begin
    rem_sh = {rem, rad[SUMSQ_W-1 -: 2]};
    trial  = {1'b0, root, 2'b01};
    take   = rem_sh >= trial;
  end

  always_comb begin
    learning   = learn_count < LEARN_CNT_W'(LEARN_SAMPLES);
    learn_done = !learning;
    sum_next   = learn_sum + LEARN_SUM_W'(root);
    count_next = learn_count + 1'b1;
    dev        = (root >= rest_value) ? root - rest_value : rest_value - root;
  end

  always_comb begin
    divisor = (dest == DEST_REST) ? DIVISOR_W'(LEARN_SAMPLES) : DIVISOR_W'(PCT_SCALE);
    recip   = (dest == DEST_REST) ? RECIP_LEARN : RECIP_PCT;
    q_est   = div_prod[RECIP_SHIFT +: DIV_NUM_W];
    q_back  = SUMSQ_W'(q_est) * SUMSQ_W'(divisor);
    // estimate is low by at most one
    fix_rem = {1'b0, num} - q_back[DIV_NUM_W:0];
    q_fix   = (fix_rem >= (DIV_NUM_W+1)'(divisor)) ? q_est + 1'b1 : q_est;
  end

  always_comb begin
    dev_high   = THRESH_W'(last_deviation) >= on_th;
    dev_low    = THRESH_W'(last_deviation) <= off_th;
    high_inc   = (high_run < cfg.on_run_length) ? high_run + 1'b1 : high_run;
    low_inc    = (low_run < cfg.off_run_length) ? low_run + 1'b1 : low_run;
    rest_below = root < rest_value;
    // rest moves by the difference over 256, truncated toward zero
    track_step = rest_below ? (rest_value - root) >> TRACK_SHIFT
                            : (root - rest_value) >> TRACK_SHIFT;
    rest_next  = rest_below ? rest_value - track_step : rest_value + track_step;
    motion_next = motion_flag;
    if (dev_high) begin
      if (high_inc >= cfg.on_run_length) begin
        motion_next = 1'b1;
      end
    end else if (dev_low) begin
      if (low_inc >= cfg.off_run_length) begin
        motion_next = 1'b0;
      end
    end
  end

  assign pop_ready = state == S_IDLE;
  assign load_out  = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      learn_count    <= '0;
      learn_sum      <= '0;
      rest_value     <= '0;
      high_run       <= '0;
      low_run        <= '0;
      motion_flag    <= 1'b0;
      last_deviation <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            rad      <= pop_data;
            rem      <= '0;
            root     <= '0;
            root_cnt <= '0;
            changed  <= 1'b0;
            state    <= S_ROOT;
          end
        end
        S_ROOT: begin
          rad      <= rad << 2;
          rem      <= take ? ROOT_REM_W'(rem_sh - trial) : ROOT_REM_W'(rem_sh);
          root     <= {root[MAG_W-2:0], take};
          root_cnt <= root_cnt + 1'b1;
          if (root_cnt == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          if (learning) begin
            learn_sum   <= sum_next;
            learn_count <= count_next;
            if (count_next == LEARN_CNT_W'(LEARN_SAMPLES)) begin
              num   <= DIV_NUM_W'(sum_next);
              dest  <= DEST_REST;
              state <= S_DMUL;
            end else begin
              state <= S_DONE;
            end
          end else if (rest_value < cfg.rest_minimum) begin
            state <= S_DONE;
          end else begin
            last_deviation <= dev;
            num   <= DIV_NUM_W'(rest_value) * DIV_NUM_W'(cfg.on_percent);
            dest  <= DEST_ON;
            state <= S_DMUL;
          end
        end
        S_DMUL: begin
          div_prod <= DIV_PROD_W'(num) * DIV_PROD_W'(recip);
          state    <= S_DFIX;
        end
        S_DFIX: begin
          case (dest)
            DEST_REST: begin
              rest_value <= q_fix[MAG_W-1:0];
              state      <= S_DONE;
            end
            DEST_ON: begin
              on_th <= q_fix[THRESH_W-1:0];
              state <= S_OFFMUL;
            end
            DEST_OFF: begin
              off_th <= q_fix[THRESH_W-1:0];
              state  <= S_DECIDE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_OFFMUL: begin
          num   <= DIV_NUM_W'(rest_value) * DIV_NUM_W'(cfg.off_percent);
          dest  <= DEST_OFF;
          state <= S_DMUL;
        end
        S_DECIDE: begin
          // on test first; between the bands both runs clear
          if (dev_high) begin
            high_run <= high_inc;
            low_run  <= '0;
          end else if (dev_low) begin
            high_run   <= '0;
            low_run    <= low_inc;
            rest_value <= rest_next;
          end else begin
            high_run <= '0;
            low_run  <= '0;
          end
          motion_flag <= motion_next;
          changed     <= motion_next != motion_flag;
          state       <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item.motion         <= motion_flag;
      out_item.motion_changed <= changed;
      out_item.magnitude      <= root;
      out_item.deviation      <= last_deviation;
      out_item.rest_level     <= rest_value;
      out_item.learned        <= learn_done;
    end
  end

  a_runs_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(high_run != '0 && low_run != '0))
    else $error("high and low runs both active");

  a_learned_sticky: assert property (@(posedge clk) disable iff (rst)
    learn_done |=> learn_done)
    else $error("learning restarted");

  a_motion_in_decide: assert property (@(posedge clk) disable iff (rst)
    (state != S_DECIDE) |=> $stable(motion_flag))
    else $error("motion flag changed outside decision step");

  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result loaded outside done step");

endmodule

>>> rtl/accel_motion_detector.sv
// Top level of the accelerometer motion detector: configuration registers,
// front end, queue and back end. Depends on amd_pkg, amd_front, amd_queue, amd_back.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_item   (amd_in_t)
//   out      out  out_valid / out_ready  out_item  (amd_out_t)
//   cfg      in   cfg_write              cfg_index, cfg_data
//
// After learning, one sample occupies the back end for accept, 16 root steps, classify,
// two reciprocal divisions, the off product, the run update and the result load; frozen
// detection skips to the load after classify. The back-end sequencer sets the rate. The
// front end registers the squares of the axes; a two-entry queue holds sums.
// Reset is synchronous; it clears the learned state and restores register defaults.
// A stalled output holds the back end in its last step; the front end and queue fill up.
module accel_motion_detector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  amd_pkg::amd_in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output amd_pkg::amd_out_t               out_item,
  input  logic                            cfg_write,
  input  logic [amd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [amd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import amd_pkg::*;

  amd_cfg_t           cfg;
  logic               push_valid;
  logic               push_ready;
  logic [SUMSQ_W-1:0] push_data;
  logic               pop_valid;
  logic               pop_ready;
  logic [SUMSQ_W-1:0] pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_percent     <= ON_PCT_RESET;
      cfg.off_percent    <= OFF_PCT_RESET;
      cfg.on_run_length  <= ON_RUN_RESET;
      cfg.off_run_length <= OFF_RUN_RESET;
      cfg.rest_minimum   <= REST_MIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ON_PERCENT:     cfg.on_percent     <= cfg_data[PCT_W-1:0];
        REG_OFF_PERCENT:    cfg.off_percent    <= cfg_data[PCT_W-1:0];
        REG_ON_RUN_LENGTH:  cfg.on_run_length  <= cfg_data[RUN_W-1:0];
        REG_OFF_RUN_LENGTH: cfg.off_run_length <= cfg_data[RUN_W-1:0];
        REG_REST_MINIMUM:   cfg.rest_minimum   <= cfg_data[MAG_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  amd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  amd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  amd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
